/* rtl/core/fxa_pkg.sv */
// ----------------------------------------------------------------------------
// fxa_pkg
// Shared types and codes for the signed Q fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fxa_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_INC = 4'd4,
    OP_DEC = 4'd5,
    OP_MIN = 4'd6,
    OP_MAX = 4'd7,
    OP_ITF = 4'd8,
    OP_FTI = 4'd9
  } fxa_op_e;

  // Per-item control and early result carried down the divider chain
  typedef struct packed {
    logic              is_div;
    logic              neg;
    logic              dz;
    logic              less;
    logic              equal;
    logic              greater;
    logic [WORD_W-1:0] result;
  } fxa_ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              less;
    logic              equal;
    logic              greater;
    logic              dz;
  } fxa_result_t;

endpackage

/* rtl/core/fxa_in_if.sv */
// ----------------------------------------------------------------------------
// fxa_in_if
// Input channel: operation code and two raw operands, valid/ready.
// ----------------------------------------------------------------------------
interface fxa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         operation;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input operation, input operand_a, input operand_b,
                  output ready);
endinterface

/* rtl/core/fxa_out_if.sv */
// ----------------------------------------------------------------------------
// fxa_out_if
// Output channel: raw result, compare flags and divide-by-zero, valid/ready.
// ----------------------------------------------------------------------------
interface fxa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               a_less;
  logic               a_equal;
  logic               a_greater;
  logic               divide_by_zero;

  modport source (output valid, output result_value, output a_less, output a_equal,
                  output a_greater, output divide_by_zero, input ready);
  modport sink   (input valid, input result_value, input a_less, input a_equal,
                  input a_greater, input divide_by_zero, output ready);
endinterface

/* rtl/core/fixed_point_q24_8_alu_top.sv */
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top
// Signed fixed-point ALU: front decode stage, a chain of restoring-division
// cells (one quotient bit per cell), and a skid-buffered output register.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_i    | in  | valid / ready | operation, operand_a, operand_b
//  out_o   | out | valid / ready | result_value, a_less, a_equal, a_greater,
//          |     |               | divide_by_zero
//
//  One item accepted per cycle while in_i.ready is high; every item passes
//  from acceptance to output through one front stage, 32 + FRACTION_BITS
//  division cells (the dividend width), and the output register.
//  Reset clears only the valid flags; payload flops are not reset.
//  A stalled output fills the skid entry, then the whole chain holds and
//  in_i.ready drops until the skid entry drains.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top #(
  parameter int FRACTION_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fxa_in_if.sink    in_i,
  fxa_out_if.source out_o
);
  import fxa_pkg::*;

  localparam int DVD_W = 32 + FRACTION_BITS;

  logic             en;
  logic             valid_s [DVD_W+1];
  fxa_ctrl_t        ctrl_s  [DVD_W+1];
  logic [31:0]      rem_s   [DVD_W+1];
  logic [DVD_W-1:0] dvd_s   [DVD_W+1];
  logic [31:0]      dsr_s   [DVD_W+1];

  fxa_ctrl_t        last;
  logic [31:0]      quot;
  fxa_result_t      res;

  assign in_i.ready = en;

  fxa_front #(
    .FRACTION_BITS (FRACTION_BITS),
    .DVD_W         (DVD_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_i.valid),
    .operation_i (in_i.operation),
    .operand_a_i (in_i.operand_a),
    .operand_b_i (in_i.operand_b),
    .valid_o     (valid_s[0]),
    .ctrl_o      (ctrl_s[0]),
    .rem_o       (rem_s[0]),
    .dvd_o       (dvd_s[0]),
    .dsr_o       (dsr_s[0])
  );

  for (genvar gi = 0; gi < DVD_W; gi++) begin : g_cell
    fxa_div_cell #(
      .DVD_W (DVD_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[gi]),
      .ctrl_i  (ctrl_s[gi]),
      .rem_i   (rem_s[gi]),
      .dvd_i   (dvd_s[gi]),
      .dsr_i   (dsr_s[gi]),
      .valid_o (valid_s[gi+1]),
      .ctrl_o  (ctrl_s[gi+1]),
      .rem_o   (rem_s[gi+1]),
      .dvd_o   (dvd_s[gi+1]),
      .dsr_o   (dsr_s[gi+1])
    );
  end

  // Apply the quotient sign and pick the divide or early result
  always_comb begin
    last        = ctrl_s[DVD_W];
    quot        = dvd_s[DVD_W][31:0];
    res.less    = last.less;
    res.equal   = last.equal;
    res.greater = last.greater;
    res.dz      = last.dz;
    if (last.is_div) begin
      if (last.dz) begin
        res.value = '0;
      end else begin
        res.value = last.neg ? (~quot + 32'd1) : quot;
      end
    end else begin
      res.value = last.result;
    end
  end

  fxa_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[DVD_W]),
    .data_i  (res),
    .ready_o (en),
    .out_o   (out_o)
  );

endmodule

/* rtl/core/fxa_front.sv */
// ----------------------------------------------------------------------------
// fxa_front
// Entry stage: decodes the operation, computes all non-divide results and the
// compare flags, and prepares operand magnitudes for the divider chain.
// ----------------------------------------------------------------------------
module fxa_front #(
  parameter int FRACTION_BITS = 8,
  parameter int DVD_W         = 40
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [3:0]                operation_i,
  input  logic signed [31:0]        operand_a_i,
  input  logic signed [31:0]        operand_b_i,
  output logic                      valid_o,
  output fxa_pkg::fxa_ctrl_t        ctrl_o,
  output logic [31:0]               rem_o,
  output logic [DVD_W-1:0]          dvd_o,
  output logic [31:0]               dsr_o
);
  import fxa_pkg::*;

  logic signed [63:0] prod;
  logic [31:0]        mag_a;
  logic [31:0]        mag_b;
  fxa_ctrl_t          ctrl_d;
  logic [DVD_W-1:0]   dvd_d;

  logic               valid_q;
  fxa_ctrl_t          ctrl_q;
  logic [DVD_W-1:0]   dvd_q;
  logic [31:0]        dsr_q;

  always_comb begin
    prod  = operand_a_i * operand_b_i;
    mag_a = operand_a_i[31] ? (~operand_a_i + 32'd1) : operand_a_i;
    mag_b = operand_b_i[31] ? (~operand_b_i + 32'd1) : operand_b_i;
    dvd_d = {mag_a, {FRACTION_BITS{1'b0}}};

    ctrl_d         = '0;
    ctrl_d.less    = operand_a_i < operand_b_i;
    ctrl_d.equal   = operand_a_i == operand_b_i;
    ctrl_d.greater = operand_a_i > operand_b_i;
    ctrl_d.neg     = operand_a_i[31] ^ operand_b_i[31];

    case (fxa_op_e'(operation_i))
      OP_ADD: ctrl_d.result = operand_a_i + operand_b_i;
      OP_SUB: ctrl_d.result = operand_a_i - operand_b_i;
      OP_MUL: ctrl_d.result = prod[FRACTION_BITS +: 32];
      OP_DIV: begin
        ctrl_d.is_div = 1'b1;
        ctrl_d.dz     = operand_b_i == 32'sd0;
      end
      OP_INC: ctrl_d.result = operand_a_i + 32'sd1;
      OP_DEC: ctrl_d.result = operand_a_i - 32'sd1;
      OP_MIN: ctrl_d.result = (operand_a_i < operand_b_i) ? operand_a_i : operand_b_i;
      OP_MAX: ctrl_d.result = (operand_a_i > operand_b_i) ? operand_a_i : operand_b_i;
      OP_ITF: ctrl_d.result = operand_a_i << FRACTION_BITS;
      OP_FTI: ctrl_d.result = operand_a_i >>> FRACTION_BITS;
      default: ctrl_d.result = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q <= ctrl_d;
      dvd_q  <= dvd_d;
      dsr_q  <= mag_b;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign rem_o   = '0;
  assign dvd_o   = dvd_q;
  assign dsr_o   = dsr_q;

endmodule

/* rtl/core/fxa_div_cell.sv */
// ----------------------------------------------------------------------------
// fxa_div_cell
// One restoring-division step: shifts in one dividend bit, retires one
// quotient bit, and hands the item on to the next cell.
// ----------------------------------------------------------------------------
module fxa_div_cell #(
  parameter int DVD_W = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  fxa_pkg::fxa_ctrl_t   ctrl_i,
  input  logic [31:0]          rem_i,
  input  logic [DVD_W-1:0]     dvd_i,
  input  logic [31:0]          dsr_i,
  output logic                 valid_o,
  output fxa_pkg::fxa_ctrl_t   ctrl_o,
  output logic [31:0]          rem_o,
  output logic [DVD_W-1:0]     dvd_o,
  output logic [31:0]          dsr_o
);
  import fxa_pkg::*;

  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             take;
  logic [31:0]      rem_d;
  logic [DVD_W-1:0] dvd_d;

  logic             valid_q;
  fxa_ctrl_t        ctrl_q;
  logic [31:0]      rem_q;
  logic [DVD_W-1:0] dvd_q;
  logic [31:0]      dsr_q;

  always_comb begin
    trial = {rem_i, dvd_i[DVD_W-1]};
    diff  = trial - {1'b0, dsr_i};
    take  = !diff[32];
    rem_d = take ? diff[31:0] : trial[31:0];
    // dividend bits leave at the top, quotient bits enter at the bottom
    dvd_d = {dvd_i[DVD_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q <= ctrl_i;
      rem_q  <= rem_d;
      dvd_q  <= dvd_d;
      dsr_q  <= dsr_i;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign rem_o   = rem_q;
  assign dvd_o   = dvd_q;
  assign dsr_o   = dsr_q;

endmodule

/* rtl/core/fxa_out_buf.sv */
// ----------------------------------------------------------------------------
// fxa_out_buf
// Output register with a one-entry skid stage; ready toward the pipeline
// comes from a flop, so the sink's ready never reaches the input side.
// ----------------------------------------------------------------------------
module fxa_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  fxa_pkg::fxa_result_t  data_i,
  output logic                  ready_o,
  fxa_out_if.source             out_o
);
  import fxa_pkg::*;

  logic        out_v_q;
  logic        skid_v_q;
  fxa_result_t out_q;
  fxa_result_t skid_q;
  logic        drain;
  logic        push;
  logic        to_skid;

  assign ready_o = !skid_v_q;
  assign drain   = out_o.ready && skid_v_q;
  assign push    = valid_i && !skid_v_q;
  assign to_skid = out_v_q && !out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (drain) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end else if (push) begin
      if (to_skid) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_q <= skid_q;
    end else if (push) begin
      if (to_skid) begin
        skid_q <= data_i;
      end else begin
        out_q <= data_i;
      end
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.result_value   = out_q.value;
  assign out_o.a_less         = out_q.less;
  assign out_o.a_equal        = out_q.equal;
  assign out_o.a_greater      = out_q.greater;
  assign out_o.divide_by_zero = out_q.dz;

endmodule
